// ----- rtl/assert_macros.svh -----
// shared assertion macros for the packet framer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define FPFB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must never hold
`define FPFB_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- rtl/fpfb_pkg.sv -----
package fpfb_pkg;

    localparam int HEADER_BYTES     = 18;
    localparam int PACKET_BYTES_DEF = 1024;
    localparam int HDR_W            = 8 * HEADER_BYTES;
    localparam int HIDX_W           = $clog2(HEADER_BYTES + 1);
    localparam int QDEPTH           = 4;
    localparam int QPTR_W           = $clog2(QDEPTH);
    localparam int QCNT_W           = $clog2(QDEPTH + 1);

    localparam logic [7:0] SYNC_HI = 8'hEB;
    localparam logic [7:0] SYNC_LO = 8'h90;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] REG_DEST     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIORITY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BATCH    = 2'd3;

    localparam logic [47:0] DEST_RST     = 48'd1;
    localparam logic [47:0] SOURCE_RST   = 48'd2;
    localparam logic [15:0] PRIORITY_RST = 16'd1;
    localparam logic [15:0] BATCH_RST    = 16'd1024;

    // one classified input item
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        start;
        logic [15:0] clen;
        logic [9:0]  pad;
        logic        eop;
        logic        eob;
    } cmd_t;

    // header fields taken from configuration
    typedef struct packed {
        logic [47:0] dest_address;
        logic [47:0] source_address;
        logic [15:0] priority_word;
    } hdr_cfg_t;

    function automatic logic [7:0] hdr_byte(logic [HIDX_W-1:0] idx, logic [15:0] clen,
                                            hdr_cfg_t cfg);
        logic [HDR_W-1:0]  v;
        logic [HIDX_W-1:0] pos;
        v   = {SYNC_HI, SYNC_LO, clen, cfg.dest_address, cfg.source_address,
               cfg.priority_word};
        pos = HIDX_W'(HEADER_BYTES - 1) - idx;
        return v[{pos, 3'b000} +: 8];
    endfunction

endpackage

// ----- rtl/fpfb_front.sv -----
module fpfb_front #(
    parameter int PACKET_BYTES = fpfb_pkg::PACKET_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [7:0]         data_byte,
    input  logic [23:0]        payload_total,
    input  logic [15:0]        batch_packets,
    input  logic               q_full,
    output logic               q_push,
    output fpfb_pkg::cmd_t     q_cmd
);
    import fpfb_pkg::*;

    localparam int CHUNK_BYTES = PACKET_BYTES - HEADER_BYTES;
    localparam int CW          = $clog2(PACKET_BYTES);

    logic [23:0]   rem_reg, rem_next;
    logic [CW-1:0] clen_reg, clen_next;
    logic [CW-1:0] off_reg, off_next;
    logic [15:0]   batch_reg, batch_next;

    logic [23:0]   rem_cur;
    logic [CW-1:0] off_cur, off_inc, pad_full;
    logic [15:0]   cnt_inc, goal;
    logic          start, eop, eob;

    assign q_push = push && !q_full;

    always_comb
    begin
        // new payload latches its length
        if (rem_reg == 24'd0)
        begin
            rem_cur = (payload_total == 24'd0) ? 24'd1 : payload_total;
            off_cur = '0;
        end
        else
        begin
            rem_cur = rem_reg;
            off_cur = off_reg;
        end
        start = (off_cur == '0);
        if (start)
            clen_next = (rem_cur < 24'(CHUNK_BYTES)) ? CW'(rem_cur) : CW'(CHUNK_BYTES);
        else
            clen_next = clen_reg;
        off_inc  = off_cur + 1'b1;
        rem_next = rem_cur - 24'd1;
        eop      = (off_inc >= clen_next);
        pad_full = CW'(CHUNK_BYTES) - clen_next;
        cnt_inc  = batch_reg + 16'd1;
        goal     = (batch_packets == 16'd0) ? 16'd1 : batch_packets;
        eob      = eop && (cnt_inc >= goal);
        off_next = eop ? '0 : off_inc;
        if (eob)
            batch_next = '0;
        else if (eop)
            batch_next = cnt_inc;
        else
            batch_next = batch_reg;

        q_cmd.data_byte = data_byte;
        q_cmd.start     = start;
        q_cmd.clen      = 16'(clen_next);
        q_cmd.pad       = eop ? 10'(pad_full) : 10'd0;
        q_cmd.eop       = eop;
        q_cmd.eob       = eob;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= '0;
            clen_reg  <= '0;
            off_reg   <= '0;
            batch_reg <= '0;
        end
        else if (q_push)
        begin
            rem_reg   <= rem_next;
            clen_reg  <= clen_next;
            off_reg   <= off_next;
            batch_reg <= batch_next;
        end
    end

endmodule

// ----- rtl/fpfb_queue.sv -----
`include "assert_macros.svh"

module fpfb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fpfb_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output fpfb_pkg::cmd_t head,
    output logic           empty
);
    import fpfb_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = slot_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_cmd;
    end

    `FPFB_ASSERT_NEVER(a_q_overflow, clk, rst_n, push && full, "push into full queue")
    `FPFB_ASSERT_IMPLY(a_q_ptrs, clk, rst_n, empty || full, wr_reg == rd_reg,
                       "queue pointers disagree with count")

endmodule

// ----- rtl/fpfb_back.sv -----
`include "assert_macros.svh"

module fpfb_back (
    input  logic              clk,
    input  logic              rst_n,
    input  fpfb_pkg::hdr_cfg_t hdr_cfg,
    input  fpfb_pkg::cmd_t    head,
    input  logic              q_empty,
    output logic              q_pop,
    input  logic              pop,
    output logic              empty,
    output logic [7:0]        out_byte,
    output logic [9:0]        pad_after,
    output logic              end_of_packet,
    output logic              end_of_batch,
    output logic              last_of_run
);
    import fpfb_pkg::*;

    logic [HIDX_W-1:0] idx_reg, idx_next;
    logic              vld_reg, vld_next;
    logic [7:0]        byte_reg;
    logic [9:0]        pad_reg;
    logic              eop_reg, eob_reg, last_reg;
    logic              emit, in_hdr;

    assign emit   = !q_empty && (!vld_reg || pop);
    assign in_hdr = head.start && (idx_reg < HIDX_W'(HEADER_BYTES));
    assign q_pop  = emit && !in_hdr;

    always_comb
    begin
        idx_next = idx_reg;
        if (emit)
            idx_next = in_hdr ? idx_reg + 1'b1 : '0;
        vld_next = emit || (vld_reg && !pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            vld_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if (in_hdr)
            begin
                byte_reg <= hdr_byte(idx_reg, head.clen, hdr_cfg);
                pad_reg  <= '0;
                eop_reg  <= 1'b0;
                eob_reg  <= 1'b0;
                last_reg <= 1'b0;
            end
            else
            begin
                byte_reg <= head.data_byte;
                pad_reg  <= head.pad;
                eop_reg  <= head.eop;
                eob_reg  <= head.eob;
                last_reg <= 1'b1;
            end
        end
    end

    assign empty         = !vld_reg;
    assign out_byte      = byte_reg;
    assign pad_after     = pad_reg;
    assign end_of_packet = eop_reg;
    assign end_of_batch  = eob_reg;
    assign last_of_run   = last_reg;

    `FPFB_ASSERT_IMPLY(a_hdr_owner, clk, rst_n, idx_reg != '0, !q_empty && head.start,
                       "header in progress without a starting item")
    `FPFB_ASSERT_IMPLY(a_hdr_done, clk, rst_n, $past(q_pop) && $past(head.start),
                       idx_reg == '0, "header counter not cleared after data byte")

endmodule

// ----- rtl/fixed_packet_framer_batcher.sv -----
// channel   | direction | handshake        | payload
// ----------+-----------+------------------+------------------------------------------
// input     | in        | push / full      | data_byte, payload_total
// result    | out       | pop / empty      | out_byte, pad_after, end_of_packet,
//           |           |                  | end_of_batch, last_of_run
// config    | in        | cfg_we           | cfg_index, cfg_data
//
// an input byte that opens a packet yields 19 result transactions (18 header bytes
// and the data byte), any other byte yields one; the back end emits one byte a cycle
// while the queue holds a command and the result register is empty or popped; while
// the 4-entry command queue has room a new byte is taken every cycle, so the long-run
// input rate is set by the back end: 1006 inputs per 1024 results for a full chunk at
// the default packet size; a push passes the queue slot and then the result register
// rst_n is asynchronous, clears payload, packet and batch state and resets config
// a stalled result side fills the queue and raises full; the result register holds
module fixed_packet_framer_batcher #(
    parameter int PACKET_BYTES = fpfb_pkg::PACKET_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input transactions
    input  logic                               push,
    output logic                               full,
    input  logic [7:0]                         data_byte,
    input  logic [23:0]                        payload_total,
    // result transactions
    output logic                               empty,
    input  logic                               pop,
    output logic [7:0]                         out_byte,
    output logic [9:0]                         pad_after,
    output logic                               end_of_packet,
    output logic                               end_of_batch,
    output logic                               last_of_run,
    // configuration writes
    input  logic                               cfg_we,
    input  logic [fpfb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fpfb_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import fpfb_pkg::*;

    // configuration registers
    logic [47:0] dest_reg;
    logic [47:0] source_reg;
    logic [15:0] prio_reg;
    logic [15:0] batch_reg;

    hdr_cfg_t hdr_cfg;

    // front to queue, queue to back
    logic q_push, q_full, q_pop, q_empty;
    cmd_t q_cmd, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_reg   <= DEST_RST;
            source_reg <= SOURCE_RST;
            prio_reg   <= PRIORITY_RST;
            batch_reg  <= BATCH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEST:     dest_reg   <= cfg_data;
                REG_SOURCE:   source_reg <= cfg_data;
                REG_PRIORITY: prio_reg   <= cfg_data[15:0];
                REG_BATCH:    batch_reg  <= cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    assign hdr_cfg.dest_address   = dest_reg;
    assign hdr_cfg.source_address = source_reg;
    assign hdr_cfg.priority_word  = prio_reg;

    // front end: latches payload length, tracks chunk offset and batch count,
    // classifies each byte as packet start / end or batch end and works out padding
    fpfb_front #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .data_byte     (data_byte),
        .payload_total (payload_total),
        .batch_packets (batch_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_cmd)
    );

    // short command queue decouples the two sides
    fpfb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    // back end: expands a packet start into the header bytes, then the data byte
    fpfb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .hdr_cfg       (hdr_cfg),
        .head          (q_head),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .out_byte      (out_byte),
        .pad_after     (pad_after),
        .end_of_packet (end_of_packet),
        .end_of_batch  (end_of_batch),
        .last_of_run   (last_of_run)
    );

    // input side stalls only on a full queue
    assign full = q_full;

    // batch end only ever rides on a packet end
    `FPFB_ASSERT_IMPLY(a_eob_eop, clk, rst_n, !empty && end_of_batch, end_of_packet,
                       "batch end without packet end")
    // padding is reported only on the closing data byte of a packet
    `FPFB_ASSERT_IMPLY(a_pad_eop, clk, rst_n, !empty && (pad_after != 10'd0),
                       end_of_packet && last_of_run, "padding on a non-final byte")

endmodule

// ----- bench/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fpfb_pkg::*;

    // data bytes per packet once the header is taken out
    localparam int CHUNK_BYTES = PACKET_BYTES_DEF - HEADER_BYTES;
    // cycles without any transaction before the run is declared hung
    localparam int HANG_LIMIT = 2000;
    // settle time after the last expected byte
    localparam int SETTLE_CYCLES = 8;

    // one input transaction as queued for the driver
    typedef struct packed {
        logic [7:0]  data;
        logic [23:0] total;
    } payload_item_t;

    // one result transaction as the framer should emit it
    typedef struct packed {
        logic [7:0] out_byte;
        logic [9:0] pad_after;
        logic       end_of_packet;
        logic       end_of_batch;
        logic       last_of_run;
    } frame_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = '0;
    logic [23:0] payload_total = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  out_byte;
    logic [9:0]  pad_after;
    logic        end_of_packet;
    logic        end_of_batch;
    logic        last_of_run;
    logic        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // bytes waiting to be pushed, and framed bytes still owed by the block
    payload_item_t pending_bytes[$];
    frame_byte_t   owed_frame_bytes[$];

    // framer state mirrored by the predictor
    logic [23:0] payload_left = '0;
    logic [9:0]  chunk_len = '0;
    logic [9:0]  chunk_pos = '0;
    logic [15:0] packets_in_batch = '0;

    // register copies, starting from their reset values
    logic [47:0] cfg_dest = DEST_RST;
    logic [47:0] cfg_source = SOURCE_RST;
    logic [15:0] cfg_priority = PRIORITY_RST;
    logic [15:0] cfg_batch = BATCH_RST;

    // run statistics
    int bytes_sent = 0;
    int bytes_checked = 0;
    int packets_framed = 0;
    int batches_closed = 0;
    int settings_used = 1;
    int mismatches = 0;

    // sender burst/gap bookkeeping and receiver stall pattern
    int            burst_left = 1;
    int            gap_left = 0;
    payload_item_t next_item;
    logic [15:0]   stall_pattern = 16'hFFFF;
    int            pattern_age = 0;
    frame_byte_t   owed;
    int            quiet_cycles = 0;

    fixed_packet_framer_batcher uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .payload_total (payload_total),
        .empty         (empty),
        .pop           (pop),
        .out_byte      (out_byte),
        .pad_after     (pad_after),
        .end_of_packet (end_of_packet),
        .end_of_batch  (end_of_batch),
        .last_of_run   (last_of_run),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // work out the framed bytes that one accepted payload byte produces
    task automatic frame_input(input logic [7:0] data, input logic [23:0] total);
        logic [8*HEADER_BYTES-1:0] header;
        frame_byte_t               fb;
        logic [15:0]               goal;
        // first byte of a payload latches its length; a zero length counts as one
        if (payload_left == 0)
        begin
            payload_left = (total == 0) ? 24'd1 : total;
            chunk_pos = '0;
        end
        // chunk start: the 18 header bytes go out ahead of the data byte
        if (chunk_pos == 0)
        begin
            chunk_len = (payload_left < CHUNK_BYTES) ? payload_left[9:0] : 10'(CHUNK_BYTES);
            header = {SYNC_HI, SYNC_LO, 6'd0, chunk_len, cfg_dest, cfg_source, cfg_priority};
            for (int k = 0; k < HEADER_BYTES; k++)
            begin
                fb = '0;
                fb.out_byte = header[8*(HEADER_BYTES-1-k) +: 8];
                owed_frame_bytes.push_back(fb);
            end
        end
        chunk_pos++;
        payload_left--;
        fb = '0;
        fb.out_byte = data;
        fb.last_of_run = 1'b1;
        // last data byte of the chunk closes the packet and reports the padding
        if (chunk_pos >= chunk_len)
        begin
            goal = (cfg_batch == 0) ? 16'd1 : cfg_batch;
            fb.pad_after = 10'(CHUNK_BYTES - chunk_len);
            fb.end_of_packet = 1'b1;
            chunk_pos = '0;
            packets_in_batch++;
            packets_framed++;
            // reaching or passing the goal closes the batch, also after it was lowered
            if (packets_in_batch >= goal)
            begin
                fb.end_of_batch = 1'b1;
                packets_in_batch = '0;
                batches_closed++;
            end
        end
        owed_frame_bytes.push_back(fb);
    endtask

    task automatic compare_field(input string field, input logic [15:0] want_v,
                                 input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
            mismatches++;
        end
    endtask

    // driver: bursts of input transactions separated by random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                frame_input(data_byte, payload_total);
                bytes_sent++;
            end
            // a raised push is held until the byte is taken
            if (!push || !full)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    push <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    next_item = pending_bytes.pop_front();
                    push <= 1'b1;
                    data_byte <= next_item.data;
                    payload_total <= next_item.total;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 48);
                        // about half the bursts run straight into the next one
                        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor: pops on a rotating stall pattern and checks every result transaction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (owed_frame_bytes.size() == 0)
                begin
                    $error("result byte %0d arrived with nothing expected", out_byte);
                    mismatches++;
                end
                else
                begin
                    owed = owed_frame_bytes.pop_front();
                    compare_field("out_byte", 16'(owed.out_byte), 16'(out_byte));
                    compare_field("pad_after", 16'(owed.pad_after), 16'(pad_after));
                    compare_field("end_of_packet", 16'(owed.end_of_packet),
                                  16'(end_of_packet));
                    compare_field("end_of_batch", 16'(owed.end_of_batch), 16'(end_of_batch));
                    compare_field("last_of_run", 16'(owed.last_of_run), 16'(last_of_run));
                    bytes_checked++;
                end
            end
            // pick a fresh pattern now and then: always ready, dense or sparse
            if (pattern_age <= 0)
            begin
                pattern_age = $urandom_range(20, 120);
                case ($urandom_range(0, 3))
                    0: stall_pattern = 16'hFFFF;
                    1: stall_pattern = 16'($urandom()) | 16'h0001;
                    2: stall_pattern = 16'($urandom() & $urandom()) | 16'h0001;
                    default: stall_pattern = 16'h0001;
                endcase
            end
            pattern_age--;
            pop <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    // watchdog: no transaction of any kind for too long means the block is stuck
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || cfg_we)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic add_byte(input logic [7:0] data, input logic [23:0] total);
        payload_item_t item;
        item.data = data;
        item.total = total;
        pending_bytes.push_back(item);
    endtask

    // later bytes of a payload carry junk in the length field, which must be ignored
    task automatic queue_payload(input logic [23:0] total, input int count);
        for (int k = 0; k < count; k++)
        begin
            add_byte(8'($urandom_range(0, 255)), (k == 0) ? total : 24'($urandom()));
        end
    endtask

    // random payloads, mostly short, until roughly the given byte count is queued
    task automatic queue_random_payloads(input int byte_goal);
        int          queued;
        logic [23:0] total;
        queued = 0;
        while (queued < byte_goal)
        begin
            case ($urandom_range(0, 9))
                0: total = 24'($urandom_range(61, 150));
                1, 2: total = 24'($urandom_range(9, 60));
                default: total = 24'($urandom_range(1, 8));
            endcase
            queue_payload(total, int'(total));
            queued += int'(total);
        end
    endtask

    // hold the sender until every owed byte is out, then let the pipeline settle
    task automatic wait_drained();
        @(negedge clk);
        while (pending_bytes.size() != 0 || push || owed_frame_bytes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // rewrite all four registers while the framer is idle
    task automatic set_config(input logic [47:0] dest, input logic [47:0] source,
                              input logic [15:0] prio, input logic [15:0] batch);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_DEST;
        cfg_data <= dest;
        @(posedge clk);
        cfg_index <= REG_SOURCE;
        cfg_data <= source;
        @(posedge clk);
        cfg_index <= REG_PRIORITY;
        cfg_data <= 48'(prio);
        @(posedge clk);
        cfg_index <= REG_BATCH;
        cfg_data <= 48'(batch);
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_dest = dest;
        cfg_source = source;
        cfg_priority = prio;
        cfg_batch = batch;
        settings_used++;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: zero length payload, one byte payload, extreme data values
        add_byte(8'h00, 24'd0);
        add_byte(8'hFF, 24'd1);
        add_byte(8'h55, 24'd2);
        add_byte(8'hAA, 24'hFFFFFF);
        wait_drained();

        // all-ones destination, zero source, top priority, batch size zero acting as one
        set_config(48'hFFFF_FFFF_FFFF, 48'h0, 16'hFFFF, 16'd0);
        add_byte(8'h01, 24'd3);
        add_byte(8'h80, 24'd0);
        add_byte(8'hFE, 24'd7);
        add_byte(8'h7F, 24'd1);
        wait_drained();

        // batches of five, then three packets so the batch is left open
        set_config(48'h0, 48'hFFFF_FFFF_FFFF, 16'h0000, 16'd5);
        add_byte(8'h11, 24'd1);
        add_byte(8'h22, 24'd1);
        add_byte(8'h33, 24'd1);
        wait_drained();

        // batch size lowered below the open count: the next packet end closes it
        set_config(48'($urandom()), 48'({$urandom(), $urandom()}), 16'($urandom()), 16'd2);
        add_byte(8'hC3, 24'd2);
        add_byte(8'h3C, 24'h123456);
        queue_random_payloads(60);
        wait_drained();

        // every packet closes a batch
        set_config(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
                   16'($urandom()), 16'd1);
        queue_random_payloads(50);
        wait_drained();

        // largest batch size, then a huge payload left open at the end of the run
        set_config(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
                   16'($urandom()), 16'hFFFF);
        queue_random_payloads(60);
        queue_payload(24'hFFFFFF, 5);
        wait_drained();

        if (owed_frame_bytes.size() != 0)
        begin
            $error("%0d result bytes never arrived", owed_frame_bytes.size());
            mismatches++;
        end
        $display("framed %0d payload bytes into %0d packets and %0d closed batches",
                 bytes_sent, packets_framed, batches_closed);
        $display("checked %0d result bytes under %0d register settings, %0d mismatches",
                 bytes_checked, settings_used, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/fpfb_pkg.sv
rtl/fpfb_front.sv
rtl/fpfb_queue.sv
rtl/fpfb_back.sv
rtl/fixed_packet_framer_batcher.sv
bench/testbench.sv
